>>> sv/graph_dfs_bfs_walker_macros.svh
// Assertion helpers shared by the walker RTL.
`ifndef GRAPH_DFS_BFS_WALKER_MACROS_SVH
`define GRAPH_DFS_BFS_WALKER_MACROS_SVH

// Condition that holds at every edge outside reset.
`define GDBW_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent in the same cycle as the antecedent.
`define GDBW_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Consequent in the cycle after the antecedent.
`define GDBW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/gdbw_pkg.sv
`timescale 1ns / 1ps

package gdbw_pkg;

	localparam int MAX_VERTICES_DEF = 16;
	localparam int DATA_BITS_DEF    = 32;

	localparam int OP_BITS     = 3;
	localparam int VERTEX_BITS = 4;
	localparam int WORD_BITS   = 32;
	localparam int STATUS_BITS = 3;

	typedef enum logic [OP_BITS-1:0] {
		OP_CLEAR      = 3'd0,
		OP_INS_VERTEX = 3'd1,
		OP_INS_EDGE   = 3'd2,
		OP_DFS        = 3'd3,
		OP_BFS        = 3'd4
	} op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK          = 3'd0,
		ST_RANGE       = 3'd1,
		ST_EXISTS      = 3'd2,
		ST_MISSING     = 3'd3,
		ST_EDGE_EXISTS = 3'd4,
		ST_NO_EDGE     = 3'd5
	} status_t;

endpackage

>>> sv/graph_dfs_bfs_walker.sv
`timescale 1ns / 1ps
// channel   signals                                          direction
// request   req_valid, req_stall, op, vertex_a, vertex_b,     in (stall out)
//           vertex_data
// response  rsp_valid, rsp_stall, status, visited_vertex,    out (stall in)
//           visited_data, last
//
// Clear, insert vertex, unknown codes, walks with no edge and edges rejected on range or
// presence go straight to S_RESP; a duplicate or self edge passes S_EDGE_A first, any
// other insert edge S_EDGE_A and S_EDGE_B. Each walk visit passes S_VISIT and S_PICK; a
// stack pop passes S_LOAD_TOP (depth first), a queue pop S_BQ and S_LOAD_TOP (breadth
// first); the single read port of the adjacency RAM paces the walk, one row per pick.
// Reset is asynchronous and clears the present bits and row valid bits; no sweep.
// A held response stalls the walk only when a second visit is ready to go out, or at its end.

`include "graph_dfs_bfs_walker_macros.svh"

module graph_dfs_bfs_walker #(
	parameter int MAX_VERTICES = gdbw_pkg::MAX_VERTICES_DEF,
	parameter int DATA_BITS    = gdbw_pkg::DATA_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [gdbw_pkg::OP_BITS-1:0]         op,
	input  logic [gdbw_pkg::VERTEX_BITS-1:0]     vertex_a,
	input  logic [gdbw_pkg::VERTEX_BITS-1:0]     vertex_b,
	input  logic signed [gdbw_pkg::WORD_BITS-1:0] vertex_data,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic [gdbw_pkg::STATUS_BITS-1:0]     status,
	output logic [gdbw_pkg::VERTEX_BITS-1:0]     visited_vertex,
	output logic signed [gdbw_pkg::WORD_BITS-1:0] visited_data,
	output logic                                 last
);

	import gdbw_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int PW = VW + 1;

	typedef logic [MAX_VERTICES-1:0] row_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RESP,
		S_EDGE_A,
		S_EDGE_B,
		S_VISIT,
		S_PICK,
		S_LOAD_TOP,
		S_BQ,
		S_FLUSH
	} state_t;

	function automatic logic [VW:0] find_low(input row_t v);
		logic [VW:0] r;
		r = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = {1'b1, VW'(i)};
			end
		end
		return r;
	endfunction

	state_t                       state_q;
	status_t                      st_q;
	row_t                         present_q;
	row_t                         row_nz_q;
	row_t                         visited_q;
	logic [VW-1:0]                a_idx_q;
	logic [VW-1:0]                b_idx_q;
	logic [VW-1:0]                top_q;
	logic [VW-1:0]                vis_q;
	logic [PW-1:0]                sp_q;
	logic [PW-1:0]                head_q;
	logic [PW-1:0]                tail_q;
	logic                         dfs_q;
	logic                         pend_valid_q;
	logic [VW-1:0]                pend_vertex_q;
	logic signed [DATA_BITS-1:0]  pend_data_q;
	logic                         rsp_valid_q;
	status_t                      rsp_status_q;
	logic [VERTEX_BITS-1:0]       rsp_vertex_q;
	logic signed [WORD_BITS-1:0]  rsp_data_q;
	logic                         rsp_last_q;
	logic                         row_ok_s1;

	logic                         accept;
	logic                         out_free;
	logic [VW-1:0]                a_idx;
	logic [VW-1:0]                b_idx;
	logic                         a_range;
	logic                         b_range;
	logic [VW:0]                  start_sel;
	logic [VW:0]                  pick_sel;
	logic                         pick_found;
	logic [VW-1:0]                pick_idx;
	row_t                         row_rd;
	logic [PW-1:0]                sp_m2;

	logic                         row_we;
	logic [VW-1:0]                row_waddr;
	row_t                         row_wdata;
	logic                         row_re;
	logic [VW-1:0]                row_raddr;
	row_t                         row_rdata;

	logic                         dat_we;
	logic [VW-1:0]                dat_waddr;
	logic [DATA_BITS-1:0]         dat_wdata;
	logic                         dat_re;
	logic [VW-1:0]                dat_raddr;
	logic [DATA_BITS-1:0]         dat_rdata;

	logic                         stk_we;
	logic [VW-1:0]                stk_waddr;
	logic [VW-1:0]                stk_wdata;
	logic                         stk_re;
	logic [VW-1:0]                stk_raddr;
	logic [VW-1:0]                stk_rdata;

	assign req_stall      = (state_q != S_IDLE);
	assign accept         = req_valid && !req_stall;
	assign out_free       = !rsp_valid_q || !rsp_stall;
	assign rsp_valid      = rsp_valid_q;
	assign status         = rsp_status_q;
	assign visited_vertex = rsp_vertex_q;
	assign visited_data   = rsp_data_q;
	assign last           = rsp_last_q;

	assign a_idx      = VW'(vertex_a);
	assign b_idx      = VW'(vertex_b);
	assign a_range    = (32'(vertex_a) >= MAX_VERTICES);
	assign b_range    = (32'(vertex_b) >= MAX_VERTICES);
	assign row_rd     = row_ok_s1 ? row_rdata : '0;
	assign start_sel  = find_low(present_q & row_nz_q);
	assign pick_sel   = find_low(row_rd & ~visited_q & present_q);
	assign pick_found = pick_sel[VW];
	assign pick_idx   = pick_sel[VW-1:0];
	assign sp_m2      = sp_q - PW'(2);

	always_comb begin
		row_we    = 1'b0;
		row_waddr = a_idx_q;
		row_wdata = row_rd | (MAX_VERTICES'(1) << b_idx_q);
		row_re    = 1'b0;
		row_raddr = top_q;
		dat_we    = 1'b0;
		dat_waddr = a_idx;
		dat_wdata = DATA_BITS'(vertex_data);
		dat_re    = 1'b0;
		dat_raddr = pick_idx;
		stk_we    = 1'b0;
		stk_waddr = dfs_q ? sp_q[VW-1:0] : tail_q[VW-1:0];
		stk_wdata = pick_idx;
		stk_re    = 1'b0;
		stk_raddr = head_q[VW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					row_re    = 1'b1;
					row_raddr = a_idx;
					dat_we    = (op == OP_INS_VERTEX) && !a_range && !present_q[a_idx];
					dat_re    = 1'b1;
					dat_raddr = start_sel[VW-1:0];
					stk_we    = 1'b1;
					stk_waddr = '0;
					stk_wdata = start_sel[VW-1:0];
				end
			end
			S_EDGE_A: begin
				row_we    = !row_rd[b_idx_q];
				row_re    = 1'b1;
				row_raddr = b_idx_q;
			end
			S_EDGE_B: begin
				row_we    = 1'b1;
				row_waddr = b_idx_q;
				row_wdata = row_rd | (MAX_VERTICES'(1) << a_idx_q);
			end
			S_VISIT: begin
				row_re = 1'b1;
			end
			S_PICK: begin
				dat_re    = pick_found;
				stk_we    = pick_found;
				stk_re    = !pick_found && dfs_q;
				stk_raddr = sp_m2[VW-1:0];
			end
			S_LOAD_TOP: begin
				row_re    = 1'b1;
				row_raddr = stk_rdata;
			end
			S_BQ: begin
				stk_re = (head_q != tail_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			st_q          <= ST_OK;
			present_q     <= '0;
			row_nz_q      <= '0;
			visited_q     <= '0;
			a_idx_q       <= '0;
			b_idx_q       <= '0;
			top_q         <= '0;
			vis_q         <= '0;
			sp_q          <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			dfs_q         <= 1'b0;
			pend_valid_q  <= 1'b0;
			pend_vertex_q <= '0;
			pend_data_q   <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_status_q  <= ST_OK;
			rsp_vertex_q  <= '0;
			rsp_data_q    <= '0;
			rsp_last_q    <= 1'b0;
			row_ok_s1     <= 1'b0;
		end else begin
			if (row_re) begin
				row_ok_s1 <= row_nz_q[row_raddr];
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						a_idx_q <= a_idx;
						b_idx_q <= b_idx;
						st_q    <= ST_OK;
						state_q <= S_RESP;
						unique case (op) inside
							OP_CLEAR: begin
								present_q <= '0;
								row_nz_q  <= '0;
								visited_q <= '0;
								sp_q      <= '0;
								head_q    <= '0;
								tail_q    <= '0;
							end
							OP_INS_VERTEX: begin
								if (a_range) begin
									st_q <= ST_RANGE;
								end else if (present_q[a_idx]) begin
									st_q <= ST_EXISTS;
								end else begin
									present_q[a_idx] <= 1'b1;
								end
							end
							OP_INS_EDGE: begin
								if (a_range || b_range) begin
									st_q <= ST_RANGE;
								end else if (!present_q[a_idx] || !present_q[b_idx]) begin
									st_q <= ST_MISSING;
								end else begin
									state_q <= S_EDGE_A;
								end
							end
							OP_DFS, OP_BFS: begin
								if (!start_sel[VW]) begin
									st_q <= ST_NO_EDGE;
								end else begin
									visited_q <= MAX_VERTICES'(1) << start_sel[VW-1:0];
									vis_q     <= start_sel[VW-1:0];
									top_q     <= start_sel[VW-1:0];
									sp_q      <= PW'(1);
									head_q    <= PW'(1);
									tail_q    <= PW'(1);
									dfs_q     <= (op == OP_DFS);
									state_q   <= S_VISIT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RESP: begin
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= st_q;
						rsp_vertex_q <= '0;
						rsp_data_q   <= '0;
						rsp_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_EDGE_A: begin
					if (row_rd[b_idx_q]) begin
						st_q    <= ST_EDGE_EXISTS;
						state_q <= S_RESP;
					end else begin
						row_nz_q[a_idx_q] <= 1'b1;
						state_q           <= (a_idx_q == b_idx_q) ? S_RESP : S_EDGE_B;
					end
				end
				S_EDGE_B: begin
					row_nz_q[b_idx_q] <= 1'b1;
					state_q           <= S_RESP;
				end
				S_VISIT: begin
					if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							rsp_valid_q  <= 1'b1;
							rsp_status_q <= ST_OK;
							rsp_vertex_q <= VERTEX_BITS'(pend_vertex_q);
							rsp_data_q   <= WORD_BITS'(pend_data_q);
							rsp_last_q   <= 1'b0;
						end
						pend_valid_q  <= 1'b1;
						pend_vertex_q <= vis_q;
						pend_data_q   <= dat_rdata;
						state_q       <= S_PICK;
					end
				end
				S_PICK: begin
					if (pick_found) begin
						visited_q[pick_idx] <= 1'b1;
						vis_q               <= pick_idx;
						if (dfs_q) begin
							sp_q  <= sp_q + PW'(1);
							top_q <= pick_idx;
						end else begin
							tail_q <= tail_q + PW'(1);
						end
						state_q <= S_VISIT;
					end else if (dfs_q) begin
						sp_q    <= sp_q - PW'(1);
						state_q <= (sp_q == PW'(1)) ? S_FLUSH : S_LOAD_TOP;
					end else begin
						state_q <= S_BQ;
					end
				end
				S_LOAD_TOP: begin
					top_q   <= stk_rdata;
					state_q <= S_PICK;
				end
				S_BQ: begin
					if (head_q == tail_q) begin
						state_q <= S_FLUSH;
					end else begin
						head_q  <= head_q + PW'(1);
						state_q <= S_LOAD_TOP;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= ST_OK;
						rsp_vertex_q <= VERTEX_BITS'(pend_vertex_q);
						rsp_data_q   <= WORD_BITS'(pend_data_q);
						rsp_last_q   <= 1'b1;
						pend_valid_q <= 1'b0;
						visited_q    <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	gdbw_ram #(
		.WIDTH(MAX_VERTICES),
		.DEPTH(MAX_VERTICES)
	) u_adj_ram (
		.clk  (clk),
		.we   (row_we),
		.waddr(row_waddr),
		.wdata(row_wdata),
		.re   (row_re),
		.raddr(row_raddr),
		.rdata(row_rdata)
	);

	gdbw_ram #(
		.WIDTH(DATA_BITS),
		.DEPTH(MAX_VERTICES)
	) u_data_ram (
		.clk  (clk),
		.we   (dat_we),
		.waddr(dat_waddr),
		.wdata(dat_wdata),
		.re   (dat_re),
		.raddr(dat_raddr),
		.rdata(dat_rdata)
	);

	gdbw_ram #(
		.WIDTH(VW),
		.DEPTH(MAX_VERTICES)
	) u_walk_ram (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_waddr),
		.wdata(stk_wdata),
		.re   (stk_re),
		.raddr(stk_raddr),
		.rdata(stk_rdata)
	);

	`GDBW_ASSERT_ALWAYS(a_queue_order, head_q <= tail_q, "queue head passed tail")
	`GDBW_ASSERT_SAME(a_idle_no_pend, state_q == S_IDLE, !pend_valid_q, "visit left pending")
	`GDBW_ASSERT_NEXT(a_pick_marks, state_q == S_PICK && pick_found, $countones(visited_q) == $past($countones(visited_q)) + 1, "pick did not mark a new vertex")
	`GDBW_ASSERT_NEXT(a_flush_done, state_q == S_FLUSH && out_free, state_q == S_IDLE && visited_q == '0 && rsp_last_q, "walk end not closed")

endmodule

>>> sv/gdbw_ram.sv
`timescale 1ns / 1ps

module gdbw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import gdbw_pkg::*;

	localparam int NV             = MAX_VERTICES_DEF;
	localparam int SETTLE_CYCLES  = 4 * NV + 8;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam logic [OP_BITS-1:0] OP_LAST_CODE = '1;

	typedef struct {
		status_t                st;
		logic [VERTEX_BITS-1:0] vtx;
		logic [WORD_BITS-1:0]   data;
		logic                   fin;
	} walk_rsp_t;

	logic                          clk         = 1'b0;
	logic                          arst_n      = 1'b0;
	logic                          req_valid   = 1'b0;
	logic                          req_stall;
	logic [OP_BITS-1:0]            op          = '0;
	logic [VERTEX_BITS-1:0]        vertex_a    = '0;
	logic [VERTEX_BITS-1:0]        vertex_b    = '0;
	logic signed [WORD_BITS-1:0]   vertex_data = '0;
	logic                          rsp_valid;
	logic                          rsp_stall   = 1'b0;
	logic [STATUS_BITS-1:0]        status;
	logic [VERTEX_BITS-1:0]        visited_vertex;
	logic signed [WORD_BITS-1:0]   visited_data;
	logic                          last;

	// graph shadow, updated as each request transfer is accepted
	logic [NV-1:0]                 g_present = '0;
	logic [WORD_BITS-1:0]          g_value [NV];
	logic [NV-1:0]                 g_adj [NV];
	walk_rsp_t                     pending_rsp [$];

	int  fail_count     = 0;
	int  send_idle_pct  = 0;
	int  recv_idle_pct  = 0;
	int  hold_left      = 0;
	bit  want_long_hold = 1'b0;
	int  quiet_cycles   = 0;

	graph_dfs_bfs_walker uut (
		.clk, .arst_n, .req_valid, .req_stall, .op, .vertex_a, .vertex_b, .vertex_data,
		.rsp_valid, .rsp_stall, .status, .visited_vertex, .visited_data, .last
	);

	always #6 clk = ~clk;

	initial begin
		foreach (g_adj[i]) g_adj[i] = '0;
		foreach (g_value[i]) g_value[i] = '0;
	end

	task automatic note_failure(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic int least_open(logic [NV-1:0] row, logic [NV-1:0] seen);
		logic [NV-1:0] cand;
		cand = row & ~seen & g_present;
		for (int i = 0; i < NV; i++)
			if (cand[i])
				return i;
		return -1;
	endfunction

	function automatic void predict_walk(input bit depth_first);
		int                     start, n, top, head, tail, cnt;
		logic [NV-1:0]          seen;
		logic [VERTEX_BITS-1:0] order [NV];
		logic [VERTEX_BITS-1:0] line [NV];
		walk_rsp_t              r;
		start = -1;
		for (int i = NV - 1; i >= 0; i--)
			if (g_present[i] && g_adj[i] != '0)
				start = i;
		if (start < 0) begin
			r = '{ST_NO_EDGE, '0, '0, 1'b1};
			pending_rsp.push_back(r);
			return;
		end
		seen = '0;
		seen[start] = 1'b1;
		order[0] = VERTEX_BITS'(start);
		line[0] = VERTEX_BITS'(start);
		cnt = 1;
		tail = 1;
		if (depth_first) begin
			while (tail > 0) begin
				n = least_open(g_adj[line[tail - 1]], seen);
				if (n >= 0) begin
					seen[n] = 1'b1;
					order[cnt] = VERTEX_BITS'(n);
					cnt++;
					line[tail] = VERTEX_BITS'(n);
					tail++;
				end else begin
					tail--;
				end
			end
		end else begin
			head = 0;
			while (head < tail) begin
				top = line[head];
				head++;
				n = least_open(g_adj[top], seen);
				while (n >= 0) begin
					seen[n] = 1'b1;
					order[cnt] = VERTEX_BITS'(n);
					cnt++;
					line[tail] = VERTEX_BITS'(n);
					tail++;
					n = least_open(g_adj[top], seen);
				end
			end
		end
		for (int i = 0; i < cnt; i++) begin
			r = '{ST_OK, order[i], g_value[order[i]], i == cnt - 1};
			pending_rsp.push_back(r);
		end
	endfunction

	function automatic void apply_request(input logic [OP_BITS-1:0] o,
			input logic [VERTEX_BITS-1:0] a, input logic [VERTEX_BITS-1:0] b,
			input logic [WORD_BITS-1:0] d);
		walk_rsp_t r;
		r = '{ST_OK, '0, '0, 1'b1};
		case (o)
			OP_CLEAR: begin
				g_present = '0;
				foreach (g_adj[i]) g_adj[i] = '0;
			end
			OP_INS_VERTEX: begin
				if (a >= NV)
					r.st = ST_RANGE;
				else if (g_present[a])
					r.st = ST_EXISTS;
				else begin
					g_present[a] = 1'b1;
					g_value[a] = d;
				end
			end
			OP_INS_EDGE: begin
				if (a >= NV || b >= NV)
					r.st = ST_RANGE;
				else if (!g_present[a] || !g_present[b])
					r.st = ST_MISSING;
				else if (g_adj[a][b])
					r.st = ST_EDGE_EXISTS;
				else begin
					g_adj[a][b] = 1'b1;
					g_adj[b][a] = 1'b1;
				end
			end
			OP_DFS: begin
				predict_walk(1'b1);
				return;
			end
			OP_BFS: begin
				predict_walk(1'b0);
				return;
			end
			default: ;
		endcase
		pending_rsp.push_back(r);
	endfunction

	task automatic send_request(input logic [OP_BITS-1:0] o, input logic [VERTEX_BITS-1:0] a,
			input logic [VERTEX_BITS-1:0] b, input logic [WORD_BITS-1:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid   <= 1'b1;
		op          <= o;
		vertex_a    <= a;
		vertex_b    <= b;
		vertex_data <= d;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		apply_request(o, a, b, d);
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [VERTEX_BITS-1:0] pick_present();
		logic [VERTEX_BITS-1:0] v;
		v = VERTEX_BITS'($urandom_range(NV - 1));
		if (g_present == '0)
			return v;
		while (!g_present[v])
			v = VERTEX_BITS'($urandom_range(NV - 1));
		return v;
	endfunction

	task automatic send_noise();
		send_request(OP_BITS'($urandom_range(int'(OP_BFS) + 1, int'(OP_LAST_CODE))),
			VERTEX_BITS'($urandom_range(NV - 1)), VERTEX_BITS'($urandom_range(NV - 1)),
			$urandom);
	endtask

	task automatic send_walk();
		send_request($urandom_range(1) ? OP_DFS : OP_BFS, VERTEX_BITS'($urandom_range(NV - 1)),
			VERTEX_BITS'($urandom_range(NV - 1)), $urandom);
	endtask

	task automatic build_and_walk(input int n_vert, input int n_link, input int n_walk);
		logic [VERTEX_BITS-1:0] a, b;
		if ($urandom_range(2) != 0)
			send_request(OP_CLEAR, VERTEX_BITS'($urandom_range(NV - 1)),
				VERTEX_BITS'($urandom_range(NV - 1)), $urandom);
		repeat (n_vert)
			send_request(OP_INS_VERTEX, VERTEX_BITS'($urandom_range(NV - 1)),
				VERTEX_BITS'($urandom_range(NV - 1)), $urandom);
		repeat (n_link) begin
			if ($urandom_range(99) < 85) begin
				a = pick_present();
				b = pick_present();
			end else begin
				a = VERTEX_BITS'($urandom_range(NV - 1));
				b = VERTEX_BITS'($urandom_range(NV - 1));
			end
			send_request(OP_INS_EDGE, a, b, $urandom);
			if ($urandom_range(9) == 0)
				send_noise();
		end
		repeat (n_walk)
			send_walk();
	endtask

	task automatic test_directed();
		send_idle_pct = 35;
		recv_idle_pct = 87;
		send_request(OP_DFS, 4'd0, 4'd0, '0);
		send_request(OP_BFS, 4'd15, 4'd15, '1);
		send_request(OP_INS_VERTEX, 4'd0, 4'd15, 32'h8000_0000);
		send_request(OP_INS_VERTEX, 4'd15, 4'd0, 32'h7FFF_FFFF);
		send_request(OP_INS_VERTEX, 4'd0, 4'd0, '0);
		send_request(OP_INS_EDGE, 4'd0, 4'd15, '0);
		send_request(OP_INS_EDGE, 4'd15, 4'd0, '0);
		send_request(OP_INS_EDGE, 4'd0, 4'd3, '0);
		send_request(OP_INS_EDGE, 4'd15, 4'd15, '1);
		send_request(OP_INS_EDGE, 4'd15, 4'd15, '1);
		for (int c = int'(OP_BFS) + 1; c <= int'(OP_LAST_CODE); c++)
			send_request(OP_BITS'(c), 4'd15, 4'd15, '1);
		send_request(OP_INS_VERTEX, 4'd5, 4'd10, 32'hFFFF_FFFF);
		send_request(OP_INS_VERTEX, 4'd3, 4'd12, '0);
		send_request(OP_INS_EDGE, 4'd5, 4'd3, '0);
		send_request(OP_INS_EDGE, 4'd0, 4'd5, '0);
		send_request(OP_DFS, 4'd0, 4'd0, '0);
		send_request(OP_BFS, 4'd0, 4'd0, '0);
		send_request(OP_CLEAR, 4'd0, 4'd0, '0);
		send_request(OP_DFS, 4'd0, 4'd0, '0);
		send_request(OP_INS_VERTEX, 4'd9, 4'd6, 32'h1234_5678);
		send_request(OP_INS_EDGE, 4'd9, 4'd9, '0);
		send_request(OP_BFS, 4'd9, 4'd9, '0);
		send_request(OP_CLEAR, 4'd15, 4'd15, '1);
		wait_for_results();
	endtask

	task automatic test_random_traffic();
		int send_pct [3] = '{35, 87, 0};
		int recv_pct [3] = '{87, 35, 0};
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = send_pct[p];
			recv_idle_pct = recv_pct[p];
			repeat (2)
				build_and_walk($urandom_range(3, 10), $urandom_range(3, 10),
					$urandom_range(2, 3));
			wait_for_results();
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		build_and_walk(10, 12, 1);
		wait_for_results();
		want_long_hold = 1'b1;
		repeat (8)
			send_walk();
		wait_for_results();
		repeat (3)
			send_walk();
		wait_for_results();
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (want_long_hold) begin
				want_long_hold = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		walk_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				note_failure($sformatf("response transfer with nothing pending: st=%0d v=%0d",
					status, visited_vertex));
			end else begin
				want = pending_rsp.pop_front();
				if (status !== want.st)
					note_failure($sformatf("status %0d, want %0d", status, want.st));
				if (visited_vertex !== want.vtx)
					note_failure($sformatf("visited_vertex %0d, want %0d",
						visited_vertex, want.vtx));
				if (visited_data !== want.data)
					note_failure($sformatf("visited_data %h, want %h",
						visited_data, want.data));
				if (last !== want.fin)
					note_failure($sformatf("last %b, want %b", last, want.fin));
			end
		end
	end

	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic();
		test_backpressure();
		if (pending_rsp.size() != 0)
			note_failure($sformatf("%0d responses never arrived", pending_rsp.size()));
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
